// File: src/rne_pkg.sv
// Shared types, codes and letter tables for the Roman numeral encoder.
`timescale 1ns / 1ps

package rne_pkg;

    localparam int NUMBER_WIDTH_DEF = 13;
    localparam int LETTER_W         = 8;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 8;
    localparam int LOW_W            = 10;
    localparam int DIGIT_W          = 4;
    localparam int SLOT_W           = 3;
    localparam int GRP_W            = 2;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int THOUSAND         = 1000;

    localparam logic [COUNT_W-1:0]  LIMIT_RESET      = 8'd255;
    localparam logic                REG_LENGTH_LIMIT = 1'b0;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [GRP_W-1:0] GRP_HUNDREDS = 2'd0;
    localparam logic [GRP_W-1:0] GRP_TENS     = 2'd1;
    localparam logic [GRP_W-1:0] GRP_UNITS    = 2'd2;

    localparam logic [1:0] SYM_ONE  = 2'd0;
    localparam logic [1:0] SYM_FIVE = 2'd1;
    localparam logic [1:0] SYM_TEN  = 2'd2;

    localparam logic [LETTER_W-1:0] CHAR_M = 8'h4D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_THOU,
        ST_GROUP,
        ST_LETTER,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                load;
        logic                emit_m;
        logic                start_grp;
        logic                emit_let;
        logic                next_grp;
        logic                emit_stat;
        logic [STATUS_W-1:0] stat_code;
    } t_cmd;

    typedef struct packed {
        logic rem_zero;
        logic ge_thou;
        logic at_limit;
        logic slot_done;
        logic grp_last;
        logic out_free;
    } t_stat;

    // Letters in a decimal digit's group
    function automatic logic [SLOT_W-1:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [SLOT_W-1:0] len;
        unique case (d)
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    // Symbol role of one slot in a digit's pattern
    function automatic logic [1:0] slot_sym(input logic [DIGIT_W-1:0] d,
                                            input logic [1:0]         slot);
        logic [1:0] sym;
        unique case (d)
            4'd4:             sym = (slot == 2'd1) ? SYM_FIVE : SYM_ONE;
            4'd9:             sym = (slot == 2'd1) ? SYM_TEN  : SYM_ONE;
            4'd5, 4'd6, 4'd7,
            4'd8:             sym = (slot == 2'd0) ? SYM_FIVE : SYM_ONE;
            default:          sym = SYM_ONE;
        endcase
        return sym;
    endfunction

    function automatic logic [LETTER_W-1:0] roman_letter(input logic [GRP_W-1:0]   grp,
                                                         input logic [DIGIT_W-1:0] d,
                                                         input logic [1:0]         slot);
        logic [1:0]          sym;
        logic [LETTER_W-1:0] ch;
        sym = slot_sym(d, slot);
        unique case (grp)
            GRP_HUNDREDS: ch = (sym == SYM_ONE) ? 8'h43 : (sym == SYM_FIVE) ? 8'h44 : 8'h4D;
            GRP_TENS:     ch = (sym == SYM_ONE) ? 8'h58 : (sym == SYM_FIVE) ? 8'h4C : 8'h43;
            default:      ch = (sym == SYM_ONE) ? 8'h49 : (sym == SYM_FIVE) ? 8'h56 : 8'h58;
        endcase
        return ch;
    endfunction

    function automatic logic [LOW_W-1:0] grp_weight(input logic [GRP_W-1:0] grp);
        logic [LOW_W-1:0] w;
        unique case (grp)
            GRP_HUNDREDS: w = 10'd100;
            GRP_TENS:     w = 10'd10;
            default:      w = 10'd1;
        endcase
        return w;
    endfunction

endpackage

// File: src/rne_ctrl.sv
// Sequencer that walks thousands, three digit groups and the closing status beat.
`timescale 1ns / 1ps

module rne_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rne_pkg::t_stat i_stat,
    output rne_pkg::t_cmd  o_cmd
);
    import rne_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_START;
            end
            ST_START: begin
                if (i_stat.rem_zero) begin
                    if (i_stat.out_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_THOU;
                end
            end
            ST_THOU: begin
                if (!i_stat.ge_thou) begin
                    n_state = ST_GROUP;
                end else if (i_stat.at_limit && i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_GROUP: begin
                if (!i_stat.at_limit) begin
                    n_state = ST_LETTER;
                end else if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LETTER: begin
                if (i_stat.slot_done) n_state = i_stat.grp_last ? ST_DONE : ST_GROUP;
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_START: begin
                o_cmd.emit_stat = i_stat.rem_zero && i_stat.out_free;
                o_cmd.stat_code = STAT_INVALID;
            end
            ST_THOU: begin
                o_cmd.emit_m    = i_stat.ge_thou && !i_stat.at_limit && i_stat.out_free;
                o_cmd.emit_stat = i_stat.ge_thou && i_stat.at_limit && i_stat.out_free;
                o_cmd.stat_code = STAT_OVERFLOW;
            end
            ST_GROUP: begin
                o_cmd.start_grp = !i_stat.at_limit;
                o_cmd.emit_stat = i_stat.at_limit && i_stat.out_free;
                o_cmd.stat_code = STAT_OVERFLOW;
            end
            ST_LETTER: begin
                o_cmd.emit_let = !i_stat.slot_done && i_stat.out_free;
                o_cmd.next_grp = i_stat.slot_done && !i_stat.grp_last;
            end
            ST_DONE: begin
                o_cmd.emit_stat = i_stat.out_free;
                o_cmd.stat_code = STAT_OK;
            end
            default: ;
        endcase
    end

endmodule

// File: src/rne_dp.sv
// Remainder, letter count, digit extraction and the output register.
`timescale 1ns / 1ps

module rne_dp #(
    parameter int NUMBER_WIDTH = rne_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [NUMBER_WIDTH-1:0]       i_number,
    input  logic [rne_pkg::COUNT_W-1:0]   i_length_limit,
    input  rne_pkg::t_cmd                 i_cmd,
    output rne_pkg::t_stat                o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rne_pkg::LETTER_W-1:0]  o_letter,
    output logic [rne_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_last
);
    import rne_pkg::*;

    logic [NUMBER_WIDTH-1:0] r_rem,   n_rem;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [GRP_W-1:0]        r_grp,   n_grp;
    logic [DIGIT_W-1:0]      r_digit, n_digit;
    logic [SLOT_W-1:0]       r_slot,  n_slot;
    logic                    r_valid;
    logic [LETTER_W-1:0]     r_letter;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_last;

    logic [LOW_W-1:0]        w_unit;
    logic [LOW_W-1:0]        w_thr;
    logic [DIGIT_W-1:0]      w_digit;
    logic [LOW_W-1:0]        w_sub;
    logic                    w_emit;

    // Digit of the current group: the remainder is below ten of its weight here
    always_comb begin
        w_unit  = grp_weight(r_grp);
        w_digit = '0;
        w_sub   = '0;
        w_thr   = '0;
        for (int k = 1; k < 10; k++) begin
            w_thr = LOW_W'(k) * w_unit;
            if (r_rem[LOW_W-1:0] >= w_thr) begin
                w_digit = DIGIT_W'(k);
                w_sub   = w_thr;
            end
        end
    end

    always_comb begin
        n_rem   = r_rem;
        n_count = r_count;
        n_grp   = r_grp;
        n_digit = r_digit;
        n_slot  = r_slot;
        if (i_cmd.load) begin
            n_rem   = i_number;
            n_count = '0;
            n_grp   = GRP_HUNDREDS;
        end
        if (i_cmd.emit_m) begin
            n_rem   = r_rem - NUMBER_WIDTH'(THOUSAND);
            n_count = r_count + COUNT_W'(1);
        end
        if (i_cmd.start_grp) begin
            n_digit = w_digit;
            n_rem   = r_rem - NUMBER_WIDTH'(w_sub);
            n_slot  = '0;
        end
        if (i_cmd.emit_let) begin
            n_slot  = r_slot + SLOT_W'(1);
            n_count = r_count + COUNT_W'(1);
        end
        if (i_cmd.next_grp) begin
            n_grp = r_grp + GRP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_count <= n_count;
        r_grp   <= n_grp;
        r_digit <= n_digit;
        r_slot  <= n_slot;
    end

    assign w_emit = i_cmd.emit_m || i_cmd.emit_let || i_cmd.emit_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_m) begin
            r_letter <= CHAR_M;
            r_status <= STAT_OK;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_let) begin
            r_letter <= roman_letter(r_grp, r_digit, r_slot[1:0]);
            r_status <= STAT_OK;
            r_last   <= 1'b0;
        end else if (i_cmd.emit_stat) begin
            r_letter <= '0;
            r_status <= i_cmd.stat_code;
            r_last   <= 1'b1;
        end
    end

    assign o_stat.rem_zero  = (r_rem == '0);
    assign o_stat.ge_thou   = (r_rem >= NUMBER_WIDTH'(THOUSAND));
    assign o_stat.at_limit  = (r_count >= i_length_limit);
    assign o_stat.slot_done = (r_slot == digit_len(r_digit));
    assign o_stat.grp_last  = (r_grp == GRP_UNITS);
    assign o_stat.out_free  = !r_valid || i_ready;

    assign o_valid  = r_valid;
    assign o_letter = r_letter;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

// File: src/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: register port, sequencer and datapath.
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------
//  number    in         i_valid / o_ready    i_number
//  letters   out        o_valid / i_ready    o_letter, o_status, o_last
//  config    in         psel/penable/pready  length_limit at byte address 0
//
//  One number is taken at a time; o_ready is high only between conversions.
//  Each conversion steps through an entry state, the thousands, a group
//  state and its letter state for each digit group, and the status beat.
//  Reset is synchronous and active low; length_limit returns to 255.
//  A stalled output beat holds the sequencer; nothing is dropped or repeated.
//
module roman_numeral_encoder #(
    parameter int NUMBER_WIDTH = rne_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // number channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [NUMBER_WIDTH-1:0]         i_number,
    // letter channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rne_pkg::LETTER_W-1:0]    o_letter,
    output logic [rne_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rne_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rne_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rne_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rne_pkg::*;

    logic [COUNT_W-1:0] r_length_limit;
    logic               w_sel_limit;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // Register port: one register, no wait states
    assign pready      = 1'b1;
    assign w_sel_limit = (paddr[APB_ADDR_W-1:2] == REG_LENGTH_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_limit) begin
            r_length_limit <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back the limit; unmapped addresses read as zero
    assign prdata = w_sel_limit ? APB_DATA_W'(r_length_limit) : '0;

    // Sequencer: decides which beat to emit next and when to stop
    rne_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath: holds the remainder and count, and drives the output register
    rne_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_number       (i_number),
        .i_length_limit (r_length_limit),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_letter       (o_letter),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

// File: sim/rne_checker.sv
// Scoreboard for the Roman numeral encoder: predicts letter beats and compares them.
`timescale 1ns / 1ps

module rne_checker #(
    parameter int NUM_W = rne_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  logic [NUM_W-1:0]               i_number,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [rne_pkg::LETTER_W-1:0]   o_letter,
    input  logic [rne_pkg::STATUS_W-1:0]   o_status,
    input  logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rne_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rne_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [rne_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             pending,
    output int                             numbers_seen,
    output int                             beats_seen,
    output int                             invalid_seen,
    output int                             overflow_seen
);
    import rne_pkg::*;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_beat;

    // roles of a symbol within one decade
    typedef enum int { ROLE_ONE, ROLE_FIVE, ROLE_TEN } t_role;

    t_beat              numeral_due[$];
    logic [COUNT_W-1:0] limit_shadow;

    initial begin
        fail_count    = 0;
        pending       = 0;
        numbers_seen  = 0;
        beats_seen    = 0;
        invalid_seen  = 0;
        overflow_seen = 0;
        limit_shadow  = LIMIT_RESET;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [LETTER_W-1:0] decade_letter(input int grp, input t_role role);
        logic [LETTER_W-1:0] ch;
        case (grp)
            0:       ch = (role == ROLE_ONE) ? "C" : (role == ROLE_FIVE) ? "D" : "M";
            1:       ch = (role == ROLE_ONE) ? "X" : (role == ROLE_FIVE) ? "L" : "C";
            default: ch = (role == ROLE_ONE) ? "I" : (role == ROLE_FIVE) ? "V" : "X";
        endcase
        return ch;
    endfunction

    function automatic void queue_letter(input logic [LETTER_W-1:0] ch);
        numeral_due.push_back(t_beat'{letter: ch, status: STAT_OK, last: 1'b0});
    endfunction

    function automatic void queue_status(input logic [STATUS_W-1:0] code);
        numeral_due.push_back(t_beat'{letter: '0, status: code, last: 1'b1});
    endfunction

    // Queue every beat that one number produces under the given limit
    function automatic void predict_numeral(input logic [NUM_W-1:0] value,
                                            input logic [COUNT_W-1:0] limit);
        int unsigned n;
        int unsigned used;
        int unsigned d;
        int unsigned digits[3];
        n    = value;
        used = 0;
        if (n == 0) begin
            queue_status(STAT_INVALID);
            return;
        end
        digits[0] = (n % 1000) / 100;
        digits[1] = (n % 100) / 10;
        digits[2] = n % 10;
        for (int unsigned m = 0; m < n / 1000; m++) begin
            if (used >= limit) begin
                queue_status(STAT_OVERFLOW);
                return;
            end
            queue_letter("M");
            used++;
        end
        for (int g = 0; g < 3; g++) begin
            d = digits[g];
            if (used >= limit) begin
                queue_status(STAT_OVERFLOW);
                return;
            end
            if (d == 9) begin
                queue_letter(decade_letter(g, ROLE_ONE));
                queue_letter(decade_letter(g, ROLE_TEN));
                used += 2;
            end else if (d == 4) begin
                queue_letter(decade_letter(g, ROLE_ONE));
                queue_letter(decade_letter(g, ROLE_FIVE));
                used += 2;
            end else begin
                if (d >= 5) begin
                    queue_letter(decade_letter(g, ROLE_FIVE));
                    used++;
                end
                for (int unsigned r = 0; r < d % 5; r++) begin
                    queue_letter(decade_letter(g, ROLE_ONE));
                    used++;
                end
            end
        end
        queue_status(STAT_OK);
    endfunction

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            numeral_due.delete();
            limit_shadow = LIMIT_RESET;
        end else begin
            // register port first, then new numbers, then the letter channel
            if (psel && penable && pready && (paddr >> 2) == REG_LENGTH_LIMIT) begin
                if (pwrite) begin
                    limit_shadow = pwdata[COUNT_W-1:0];
                end else if (prdata !== APB_DATA_W'(limit_shadow)) begin
                    report_mismatch($sformatf("length_limit read 0x%0h, want 0x%0h",
                                              prdata, limit_shadow));
                end
            end
            if (i_valid && o_ready) begin
                numbers_seen++;
                predict_numeral(i_number, limit_shadow);
            end
            if (o_valid && i_ready) begin
                beats_seen++;
                if (numeral_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat letter 0x%0h status %0d last %0b",
                                              o_letter, o_status, o_last));
                end else begin
                    want = numeral_due.pop_front();
                    if (o_letter !== want.letter)
                        report_mismatch($sformatf("letter 0x%0h, want 0x%0h",
                                                  o_letter, want.letter));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_status, want.status));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                    if (want.last && want.status == STAT_INVALID) invalid_seen++;
                    if (want.last && want.status == STAT_OVERFLOW) overflow_seen++;
                end
            end
        end
        pending = numeral_due.size();
    end

endmodule

// File: sim/tb_roman_numeral_encoder.sv
// Testbench top for the Roman numeral encoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_roman_numeral_encoder;
    import rne_pkg::*;

    localparam int NUM_W            = NUMBER_WIDTH_DEF;
    localparam int CLK_HALF         = 10;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 30;
    localparam int N_PHASES         = 11;
    localparam int HOLD_LEN         = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int REG_SPARE        = 1;    // index with no register behind it
    localparam int LIMIT_RANDOM     = -1;   // marks a phase whose limit is drawn at random
    localparam int NUM_MAX          = (1 << NUM_W) - 1;

    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT = APB_ADDR_W'(4 * REG_LENGTH_LIMIT);
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = APB_ADDR_W'(4 * REG_SPARE);

    // receiver behaviour, redrawn every so often
    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [NUM_W-1:0]      i_number;
    logic                  o_valid;
    logic                  i_ready;
    logic [LETTER_W-1:0]   o_letter;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int numbers_seen;
    int beats_seen;
    int invalid_seen;
    int overflow_seen;
    int cycles;
    int hold_seq;          // bumped by the stimulus to ask the receiver for a long hold
    int limits_written;

    roman_numeral_encoder #(
        .NUMBER_WIDTH(NUM_W)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_number (i_number),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_letter (o_letter),
        .o_status (o_status),
        .o_last   (o_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rne_checker #(
        .NUM_W(NUM_W)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_letter      (o_letter),
        .o_status      (o_status),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .numbers_seen  (numbers_seen),
        .beats_seen    (beats_seen),
        .invalid_seen  (invalid_seen),
        .overflow_seen (overflow_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a run that has not finished by now has hung somewhere
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("watchdog: %0d cycles passed, %0d beats still outstanding",
                 CYCLE_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stall on a randomly redrawn pattern, and hold off
    // for a long stretch whenever the stimulus asks, so the block backs up.
    initial begin
        t_rx_mode mode;
        int       rx_cyc;
        int       hold_left;
        int       hold_seen;
        mode      = RX_OPEN;
        rx_cyc    = 0;
        hold_left = 0;
        hold_seen = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_LEN;
            end
            if (rx_cyc % 50 == 0) mode = t_rx_mode'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (rx_cyc % 3 != 0);
                endcase
            end
        end
    end

    // Offer one number and hold it until the block takes the beat.
    // Valid stays high on return so a following beat can go back to back.
    task automatic send_number(input logic [NUM_W-1:0] value);
        i_valid  <= 1'b1;
        i_number <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic apb_access(input logic is_write,
                              input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle before the next transfer
        @(posedge i_clk);
    endtask

    // Hold the sender until every predicted beat has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Half full-range values, the rest leaning towards short numerals,
    // round thousands and the awkward corners.
    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, NUM_MAX);
            5, 6:          v = $urandom_range(1, 99);
            7:             v = $urandom_range(0, 9);
            8:             v = 1000 * $urandom_range(1, 8) + $urandom_range(0, 3);
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = NUM_MAX;
                    2:       v = 3888;
                    default: v = 7888;
                endcase
            end
        endcase
        return NUM_W'(v);
    endfunction

    // Send numbers in bursts of random length; gaps between bursts are random,
    // and sometimes absent so long runs go back to back.
    task automatic feed_numbers(input int total);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < total; b++) begin
                send_number(pick_number());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int                    limit_plan[N_PHASES];
        int                    directed[$];
        int                    lim;
        logic [APB_DATA_W-1:0] word;

        // limits: the extremes, values that cut a numeral mid-way, random picks
        limit_plan = '{0, 1, 2, 3, 5, 8, 13, 255, LIMIT_RANDOM, LIMIT_RANDOM, 255};
        // zero, single digits, every subtractive group, the longest numerals,
        // round thousands, the largest value and alternating bit patterns
        directed = '{0, 1, 4, 9, 3888, 7888, NUM_MAX, 1000, 8000, 444, 999, 1994,
                     2049, 4095, 5555, 6666, 90, 900, 49, 2730, 5461};

        hold_seq       = 0;
        limits_written = 0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_number <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed numbers under the reset limit; read it back first
        apb_access(1'b0, ADDR_LIMIT, '0);
        foreach (directed[k]) send_number(NUM_W'(directed[k]));
        i_valid <= 1'b0;

        foreach (limit_plan[p]) begin
            // drain before touching the register so no conversion is in flight
            wait_drained();
            lim  = (limit_plan[p] == LIMIT_RANDOM) ? $urandom_range(0, 255) : limit_plan[p];
            word = $urandom;
            word[COUNT_W-1:0] = COUNT_W'(lim);
            apb_access(1'b1, ADDR_LIMIT, word);
            apb_access(1'b0, ADDR_LIMIT, '0);
            limits_written++;
            if (p == 2) begin
                // a write to the unused index must leave the limit alone
                apb_access(1'b1, ADDR_SPARE, $urandom);
                apb_access(1'b0, ADDR_LIMIT, '0);
            end
            if (p == 0) begin
                // zero limit: zero still reports invalid, anything else overflows
                send_number('0);
                send_number(NUM_W'(1));
                send_number(NUM_W'(NUM_MAX));
            end
            // ask for a long receiver hold while the sender keeps offering
            if (p == 4) hold_seq++;
            feed_numbers(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d numbers, %0d letter beats (%0d invalid, %0d overflow)",
                 numbers_seen, beats_seen, invalid_seen, overflow_seen);
        $display("summary: %0d limit settings incl. 0 and 255, %0d-cycle receiver hold",
                 limits_written, HOLD_LEN);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rne_pkg.sv
src/rne_ctrl.sv
src/rne_dp.sv
src/roman_numeral_encoder.sv
sim/rne_checker.sv
sim/tb_roman_numeral_encoder.sv
